[rtl/snfcs_pkg.sv]
// ----------------------------------------------------------------------------
// snfcs_pkg: shared types and constants for the SPI NOR flash sequencer
// Payload structs, phase codes, action and outcome codes, flash opcodes.
// ----------------------------------------------------------------------------
`default_nettype none
package snfcs_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  operation;
    logic [23:0] address;
    logic [12:0] length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] spi_out_byte;
    logic [7:0] host_byte;
    logic [1:0] outcome;
    logic       last;
  } out_item_t;

  typedef enum logic [4:0] {
    P_IDLE, P_RDSR_CMD, P_RDSR_DATA, P_WREN_CMD, P_DELAY, P_CMD_ADDR,
    P_READ_DATA, P_WR_NEED, P_WR_SEND, P_PRE_CMD,
    K_STATUS_REPORT, K_WREN_RDSR, K_WREN_CHECK, K_POLL_CHECK, K_POLL_NEXT,
    K_PRE_SECOND, K_PRE_THIRD, K_DONE_OK
  } phase_t;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_SPI   = 2'd1;
  localparam logic [1:0] REQ_DATA  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [3:0] OP_STATUS = 4'd0;
  localparam logic [3:0] OP_WREN   = 4'd1;
  localparam logic [3:0] OP_ID     = 4'd2;
  localparam logic [3:0] OP_RESET  = 4'd3;
  localparam logic [3:0] OP_WAKE   = 4'd4;
  localparam logic [3:0] OP_READ   = 4'd5;
  localparam logic [3:0] OP_ER4K   = 4'd6;
  localparam logic [3:0] OP_ER64K  = 4'd7;
  localparam logic [3:0] OP_CHIP   = 4'd8;
  localparam logic [3:0] OP_WRITE  = 4'd9;

  localparam logic [2:0] ACT_SEL    = 3'd0;
  localparam logic [2:0] ACT_DESEL  = 3'd1;
  localparam logic [2:0] ACT_SEND   = 3'd2;
  localparam logic [2:0] ACT_HOST   = 3'd3;
  localparam logic [2:0] ACT_NEED   = 3'd4;
  localparam logic [2:0] ACT_DONE   = 3'd5;

  localparam logic [1:0] OC_OK      = 2'd0;
  localparam logic [1:0] OC_BADARG  = 2'd1;
  localparam logic [1:0] OC_NOWEL   = 2'd2;
  localparam logic [1:0] OC_TIMEOUT = 2'd3;

  localparam logic [1:0] CFG_SECTOR = 2'd0;
  localparam logic [1:0] CFG_BLOCK  = 2'd1;
  localparam logic [1:0] CFG_CHIP   = 2'd2;
  localparam logic [1:0] CFG_PAGE   = 2'd3;

  localparam logic [7:0] OPC_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] OPC_READ_STATUS  = 8'h05;
  localparam logic [7:0] OPC_READ_DATA    = 8'h03;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_BE    = 8'hD8;
  localparam logic [7:0] CMD_CE    = 8'hC7;
  localparam logic [7:0] CMD_RDID  = 8'h9F;
  localparam logic [7:0] CMD_WAKE  = 8'hAB;
  localparam logic [7:0] OPC_RESET_ENABLE = 8'h66;
  localparam logic [7:0] CMD_RST   = 8'h99;
  localparam logic [7:0] DUMMY     = 8'hFF;

  localparam logic [9:0] TICKS_WEL  = 10'd10;
  localparam logic [9:0] TICKS_PRE  = 10'd50;
  localparam logic [9:0] TICKS_MS   = 10'd1000;

endpackage
`default_nettype wire

[rtl/spi_nor_flash_command_sequencer.sv]
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer: byte-level SPI NOR flash operation engine
// One event beat in, up to three result beats out, single-pass state update.
// ----------------------------------------------------------------------------
//  channel  | signals                    | direction
//  in       | in_valid/in_ready/in_data  | event beats into the block
//  out      | out_valid/out_ready/out_data| result beats out, last marks end
//  cfg      | cfg_valid/cfg_ready/idx/data| timeout register writes
//
// An input beat is decoded in the cycle it is accepted; its results (none to
// three) go into a small result buffer and drain one per cycle. The next beat
// is accepted when the buffer will hold it, so beats that give one result
// sustain one per cycle. Reset is synchronous and clears all state and the
// timeout registers to their defaults. Output stalls only back up the input.
// ----------------------------------------------------------------------------
`default_nettype none
module spi_nor_flash_command_sequencer #(
  parameter int MAX_LEN    = 4096,
  parameter int PAGE_BYTES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire snfcs_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output snfcs_pkg::out_item_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [19:0]          cfg_data
);
  import snfcs_pkg::*;

  localparam int PW = $clog2(PAGE_BYTES);

  // timeout registers
  logic [19:0] to_sector, to_block, to_chip, to_page;

  // sequencer state
  phase_t      phase, return_phase;
  logic [3:0]  cur_op;
  logic [23:0] cursor;
  logic [12:0] remain;
  logic [12:0] chunk;
  logic [1:0]  step;
  logic [9:0]  dcount;
  logic [26:0] elapsed;
  logic [7:0]  status;

  phase_t      phase_next, return_phase_next;
  logic [3:0]  cur_op_next;
  logic [23:0] cursor_next;
  logic [12:0] remain_next, chunk_next;
  logic [1:0]  step_next;
  logic [9:0]  dcount_next;
  logic [26:0] elapsed_next;
  logic [7:0]  status_next;

  // result buffer: FIFO of depth 8, filled with up to three results per beat
  out_item_t   fifo [8];
  logic [2:0]  rd_ptr, wr_ptr;
  logic [3:0]  count;
  out_item_t   res [4];
  logic [2:0]  res_n;
  logic        take;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count <= 4'd4);
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      to_sector <= 20'd5000;
      to_block  <= 20'd15000;
      to_chip   <= 20'd120000;
      to_page   <= 20'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SECTOR: to_sector <= cfg_data;
        CFG_BLOCK:  to_block  <= cfg_data;
        CFG_CHIP:   to_chip   <= cfg_data;
        CFG_PAGE:   to_page   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // decode one event beat
  always_comb begin
    logic [1:0]  oc;
    logic [19:0] tmo;
    logic [7:0]  b;
    logic [12:0] room;
    logic [12:0] r2;
    logic [12:0] c2;
    phase_t      k;
    logic        cont;
    logic        wait_go;
    logic        page_go;
    phase_next        = phase;
    return_phase_next = return_phase;
    cur_op_next       = cur_op;
    cursor_next       = cursor;
    remain_next       = remain;
    chunk_next        = chunk;
    step_next         = step;
    dcount_next       = dcount;
    elapsed_next      = elapsed;
    status_next       = status;
    res_n             = 3'd0;
    for (int i = 0; i < 4; i++) res[i] = '0;
    oc      = OC_OK;
    b       = in_data.data_byte;
    k       = P_IDLE;
    cont    = 1'b0;
    wait_go = 1'b0;
    page_go = 1'b0;
    r2      = '0;
    c2      = '0;
    room    = '0;
    tmo     = '0;

    case (in_data.req_type)
      REQ_START: begin
        if (phase == P_IDLE) begin
          cur_op_next = in_data.operation;
          case (in_data.operation)
            OP_STATUS: begin
              res[0].action = ACT_SEL;
              res[1].action = ACT_SEND; res[1].spi_out_byte = OPC_READ_STATUS;
              res_n = 3'd2; return_phase_next = K_STATUS_REPORT;
              phase_next = P_RDSR_CMD;
            end
            OP_WREN, OP_CHIP: begin
              res[0].action = ACT_SEL;
              res[1].action = ACT_SEND; res[1].spi_out_byte = OPC_WRITE_ENABLE;
              res_n = 3'd2; phase_next = P_WREN_CMD;
            end
            OP_ID, OP_RESET: begin
              res[0].action = ACT_DESEL; res_n = 3'd1;
              dcount_next = TICKS_PRE; return_phase_next = K_PRE_SECOND;
              phase_next = P_DELAY;
            end
            OP_WAKE: begin
              res[0].action = ACT_SEL;
              res[1].action = ACT_SEND; res[1].spi_out_byte = CMD_WAKE;
              res_n = 3'd2; step_next = 2'd3; phase_next = P_CMD_ADDR;
            end
            OP_READ: begin
              if (32'(in_data.length) > MAX_LEN) begin
                res[0].action = ACT_DONE; res[0].outcome = OC_BADARG;
                res_n = 3'd1; phase_next = P_IDLE;
              end else begin
                cursor_next = in_data.address; remain_next = in_data.length;
                res[0].action = ACT_SEL;
                res[1].action = ACT_SEND; res[1].spi_out_byte = OPC_READ_DATA;
                res_n = 3'd2; step_next = 2'd0; phase_next = P_CMD_ADDR;
              end
            end
            OP_ER4K, OP_ER64K: begin
              if ((in_data.operation == OP_ER4K && in_data.address[11:0] != 12'd0) ||
                  (in_data.operation == OP_ER64K && in_data.address[15:0] != 16'd0)) begin
                res[0].action = ACT_DONE; res[0].outcome = OC_BADARG;
                res_n = 3'd1; phase_next = P_IDLE;
              end else begin
                cursor_next = in_data.address;
                res[0].action = ACT_SEL;
                res[1].action = ACT_SEND; res[1].spi_out_byte = OPC_WRITE_ENABLE;
                res_n = 3'd2; phase_next = P_WREN_CMD;
              end
            end
            OP_WRITE: begin
              if (32'(in_data.length) > MAX_LEN) begin
                res[0].action = ACT_DONE; res[0].outcome = OC_BADARG;
                res_n = 3'd1; phase_next = P_IDLE;
              end else if (in_data.length == 13'd0) begin
                cursor_next = in_data.address; remain_next = '0;
                res[0].action = ACT_DONE; res_n = 3'd1; phase_next = P_IDLE;
              end else begin
                cursor_next = in_data.address; remain_next = in_data.length;
                room = 13'(PAGE_BYTES) - 13'(in_data.address[PW-1:0]);
                chunk_next = (in_data.length < room) ? in_data.length : room;
                res[0].action = ACT_SEL;
                res[1].action = ACT_SEND; res[1].spi_out_byte = OPC_WRITE_ENABLE;
                res_n = 3'd2; phase_next = P_WREN_CMD;
              end
            end
            default: begin
              res[0].action = ACT_DONE; res[0].outcome = OC_BADARG;
              res_n = 3'd1; phase_next = P_IDLE;
            end
          endcase
        end
      end
      REQ_TICK: begin
        if (phase == P_DELAY) begin
          if (dcount != 10'd0) dcount_next = dcount - 10'd1;
          if (dcount <= 10'd1) begin
            cont = 1'b1; k = return_phase;
          end
        end
      end
      REQ_DATA: begin
        if (phase == P_WR_NEED) begin
          res[0].action = ACT_SEND; res[0].spi_out_byte = b;
          res_n = 3'd1; phase_next = P_WR_SEND;
        end
      end
      default: begin
        case (phase)
          P_RDSR_CMD: begin
            res[0].action = ACT_SEND; res[0].spi_out_byte = DUMMY;
            res_n = 3'd1; phase_next = P_RDSR_DATA;
          end
          P_RDSR_DATA: begin
            status_next = b;
            res[0].action = ACT_DESEL; res_n = 3'd1;
            cont = 1'b1; k = return_phase;
          end
          P_WREN_CMD: begin
            res[0].action = ACT_DESEL; res_n = 3'd1;
            dcount_next = TICKS_WEL; return_phase_next = K_WREN_RDSR;
            phase_next = P_DELAY;
          end
          P_PRE_CMD: begin
            res[0].action = ACT_DESEL; res_n = 3'd1;
            dcount_next = TICKS_PRE; return_phase_next = K_PRE_THIRD;
            phase_next = P_DELAY;
          end
          P_CMD_ADDR: begin
            if (step != 2'd3) begin
              res[0].action = ACT_SEND;
              case (step)
                2'd0:    res[0].spi_out_byte = cursor[23:16];
                2'd1:    res[0].spi_out_byte = cursor[15:8];
                default: res[0].spi_out_byte = cursor[7:0];
              endcase
              res_n = 3'd1; step_next = step + 2'd1;
            end else begin
              case (cur_op)
                OP_ID: begin
                  remain_next = 13'd3;
                  res[0].action = ACT_SEND; res[0].spi_out_byte = DUMMY;
                  res_n = 3'd1; phase_next = P_READ_DATA;
                end
                OP_RESET, OP_WAKE: begin
                  res[0].action = ACT_DESEL; res_n = 3'd1;
                  dcount_next = TICKS_MS; return_phase_next = K_DONE_OK;
                  phase_next = P_DELAY;
                end
                OP_READ: begin
                  if (remain == 13'd0) begin
                    res[0].action = ACT_DESEL; res[1].action = ACT_DONE;
                    res_n = 3'd2; phase_next = P_IDLE;
                  end else begin
                    res[0].action = ACT_SEND; res[0].spi_out_byte = DUMMY;
                    res_n = 3'd1; phase_next = P_READ_DATA;
                  end
                end
                OP_WRITE: begin
                  res[0].action = ACT_NEED; res_n = 3'd1; phase_next = P_WR_NEED;
                end
                default: begin
                  res[0].action = ACT_DESEL; res_n = 3'd1; wait_go = 1'b1;
                end
              endcase
            end
          end
          P_READ_DATA: begin
            res[0].action = ACT_HOST; res[0].host_byte = b;
            r2 = (remain != 13'd0) ? remain - 13'd1 : 13'd0;
            remain_next = r2;
            if (r2 != 13'd0) begin
              res[1].action = ACT_SEND; res[1].spi_out_byte = DUMMY; res_n = 3'd2;
            end else begin
              res[1].action = ACT_DESEL; res[2].action = ACT_DONE;
              res_n = 3'd3; phase_next = P_IDLE;
            end
          end
          P_WR_SEND: begin
            c2 = (chunk != 13'd0) ? chunk - 13'd1 : 13'd0;
            chunk_next = c2;
            remain_next = (remain != 13'd0) ? remain - 13'd1 : 13'd0;
            cursor_next = cursor + 24'd1;
            if (c2 != 13'd0) begin
              res[0].action = ACT_NEED; res_n = 3'd1; phase_next = P_WR_NEED;
            end else begin
              res[0].action = ACT_DESEL; res_n = 3'd1; wait_go = 1'b1;
            end
          end
          default: ;
        endcase
      end
    endcase

    // resume at a continuation point (appends at res_n)
    if (cont) begin
      case (k)
        K_STATUS_REPORT: begin
          res[res_n[1:0]].action = ACT_HOST; res[res_n[1:0]].host_byte = status_next;
          res[res_n[1:0]+2'd1].action = ACT_DONE;
          res_n = res_n + 3'd2; phase_next = P_IDLE;
        end
        K_WREN_RDSR: begin
          res[res_n[1:0]].action = ACT_SEL;
          res[res_n[1:0]+2'd1].action = ACT_SEND;
          res[res_n[1:0]+2'd1].spi_out_byte = OPC_READ_STATUS;
          res_n = res_n + 3'd2; return_phase_next = K_WREN_CHECK;
          phase_next = P_RDSR_CMD;
        end
        K_WREN_CHECK: begin
          if (cur_op == OP_WREN) begin
            res[res_n[1:0]].action = ACT_HOST; res[res_n[1:0]].host_byte = status_next;
            res[res_n[1:0]+2'd1].action = ACT_DONE;
            res[res_n[1:0]+2'd1].outcome = status_next[1] ? OC_OK : OC_NOWEL;
            res_n = res_n + 3'd2; phase_next = P_IDLE;
          end else if (!status_next[1]) begin
            res[res_n[1:0]].action = ACT_DONE; res[res_n[1:0]].outcome = OC_NOWEL;
            res_n = res_n + 3'd1; phase_next = P_IDLE;
          end else begin
            case (cur_op)
              OP_ER4K:  b = CMD_SE;
              OP_ER64K: b = CMD_BE;
              OP_CHIP:  b = CMD_CE;
              default:  b = CMD_PP;
            endcase
            res[res_n[1:0]].action = ACT_SEL;
            res[res_n[1:0]+2'd1].action = ACT_SEND;
            res[res_n[1:0]+2'd1].spi_out_byte = b;
            res_n = res_n + 3'd2;
            step_next = (cur_op == OP_CHIP) ? 2'd3 : 2'd0;
            phase_next = P_CMD_ADDR;
          end
        end
        K_POLL_CHECK: begin
          if (status_next[0]) begin
            dcount_next = TICKS_MS; return_phase_next = K_POLL_NEXT;
            phase_next = P_DELAY;
          end else if (cur_op == OP_WRITE && remain != 13'd0) begin
            page_go = 1'b1;
          end else begin
            res[res_n[1:0]].action = ACT_DONE;
            res_n = res_n + 3'd1; phase_next = P_IDLE;
          end
        end
        K_POLL_NEXT: begin
          elapsed_next = elapsed + 27'd1;
        end
        K_PRE_SECOND: begin
          res[res_n[1:0]].action = ACT_SEL;
          res[res_n[1:0]+2'd1].action = ACT_SEND;
          res[res_n[1:0]+2'd1].spi_out_byte =
            (cur_op == OP_ID) ? CMD_WAKE : OPC_RESET_ENABLE;
          res_n = res_n + 3'd2; phase_next = P_PRE_CMD;
        end
        K_PRE_THIRD: begin
          res[res_n[1:0]].action = ACT_SEL;
          res[res_n[1:0]+2'd1].action = ACT_SEND;
          res[res_n[1:0]+2'd1].spi_out_byte = (cur_op == OP_ID) ? CMD_RDID : CMD_RST;
          res_n = res_n + 3'd2; step_next = 2'd3; phase_next = P_CMD_ADDR;
        end
        default: begin
          res[res_n[1:0]].action = ACT_DONE;
          res_n = res_n + 3'd1; phase_next = P_IDLE;
        end
      endcase
    end

    // start the next page of a write
    if (page_go) begin
      room = 13'(PAGE_BYTES) - 13'(cursor[PW-1:0]);
      chunk_next = (remain < room) ? remain : room;
      res[res_n[1:0]].action = ACT_SEL;
      res[res_n[1:0]+2'd1].action = ACT_SEND;
      res[res_n[1:0]+2'd1].spi_out_byte = OPC_WRITE_ENABLE;
      res_n = res_n + 3'd2; phase_next = P_WREN_CMD;
    end

    // busy poll: check timeout, then read status
    if (wait_go || (cont && k == K_POLL_NEXT)) begin
      if (wait_go) elapsed_next = '0;
      case (cur_op)
        OP_ER4K:  tmo = to_sector;
        OP_ER64K: tmo = to_block;
        OP_CHIP:  tmo = to_chip;
        default:  tmo = to_page;
      endcase
      if (elapsed_next >= 27'(tmo)) begin
        oc = OC_TIMEOUT;
        res[res_n[1:0]].action = ACT_DONE; res[res_n[1:0]].outcome = oc;
        res_n = res_n + 3'd1; phase_next = P_IDLE;
      end else begin
        res[res_n[1:0]].action = ACT_SEL;
        res[res_n[1:0]+2'd1].action = ACT_SEND;
        res[res_n[1:0]+2'd1].spi_out_byte = OPC_READ_STATUS;
        res_n = res_n + 3'd2; return_phase_next = K_POLL_CHECK;
        phase_next = P_RDSR_CMD;
      end
    end

    for (int i = 0; i < 4; i++) res[i].last = (3'(i) == res_n - 3'd1);
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE; return_phase <= P_IDLE; cur_op <= '0; cursor <= '0;
      remain <= '0; chunk <= '0; step <= '0; dcount <= '0; elapsed <= '0;
      status <= '0;
    end else if (take) begin
      phase <= phase_next; return_phase <= return_phase_next;
      cur_op <= cur_op_next; cursor <= cursor_next; remain <= remain_next;
      chunk <= chunk_next; step <= step_next; dcount <= dcount_next;
      elapsed <= elapsed_next; status <= status_next;
    end
  end

  // result buffer write and drain
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < res_n) fifo[wr_ptr + 3'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0; wr_ptr <= '0; count <= '0;
    end else begin
      if (take) wr_ptr <= wr_ptr + res_n;
      if (out_valid && out_ready) rd_ptr <= rd_ptr + 3'd1;
      count <= count + (take ? {1'b0, res_n} : 4'd0)
                     - ((out_valid && out_ready) ? 4'd1 : 4'd0);
    end
  end

  assign out_valid = (count != 4'd0);
  assign out_data  = fifo[rd_ptr];

endmodule
`default_nettype wire

[test/spi_nor_flash_command_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_tb: self-checking bench for the sequencer
// A flash responder answers each request the block makes (SPI bytes, data,
// ticks) with random content and some noise. A scoreboard predicts every
// result beat and checks it. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module spi_nor_flash_command_sequencer_tb;
  import snfcs_pkg::*;

  localparam int ITEMS     = 300;
  localparam int LATENCY   = 12;
  localparam int WDOG_MAX  = 5000;
  localparam int HOLD_OFF  = 300;

  // Flash operation predictor plus queue of pending result beats
  class flash_scoreboard;
    phase_t      ph, ret;
    logic [3:0]  op;
    logic [23:0] cur;
    logic [12:0] rem;
    logic [8:0]  chunk;
    logic [2:0]  step;
    logic [9:0]  dcnt;
    logic [26:0] elapsed;
    logic [7:0]  stat;
    logic [19:0] tmo [4];
    out_item_t   burst[$];
    out_item_t   pending[$];
    int          errors;

    function new();
      ph = P_IDLE; ret = P_IDLE; op = '0; cur = '0; rem = '0; chunk = '0;
      step = '0; dcnt = '0; elapsed = '0; stat = '0; errors = 0;
      tmo[CFG_SECTOR] = 20'd5000;
      tmo[CFG_BLOCK]  = 20'd15000;
      tmo[CFG_CHIP]   = 20'd120000;
      tmo[CFG_PAGE]   = 20'd1000;
    endfunction

    function void set_timeout(logic [1:0] idx, logic [19:0] val);
      tmo[idx] = val;
    endfunction

    function void put(logic [2:0] a, logic [7:0] s, logic [7:0] h, logic [1:0] o);
      out_item_t r;
      r = '{action: a, spi_out_byte: s, host_byte: h, outcome: o, last: 1'b0};
      if (burst.size() < 4) burst.push_back(r);
    endfunction

    function void sel();           put(ACT_SEL, 8'h00, 8'h00, OC_OK); endfunction
    function void desel();         put(ACT_DESEL, 8'h00, 8'h00, OC_OK); endfunction
    function void send(logic [7:0] b); put(ACT_SEND, b, 8'h00, OC_OK); endfunction
    function void done(logic [1:0] oc);
      put(ACT_DONE, 8'h00, 8'h00, oc);
      ph = P_IDLE;
    endfunction

    function void wait_ticks(logic [9:0] n, phase_t k);
      dcnt = n; ret = k; ph = P_DELAY;
    endfunction

    function void status_read(phase_t k);
      sel(); send(OPC_READ_STATUS); ret = k; ph = P_RDSR_CMD;
    endfunction

    function void write_enable();
      sel(); send(OPC_WRITE_ENABLE); ph = P_WREN_CMD;
    endfunction

    function void poll_busy();
      logic [19:0] lim;
      case (op)
        OP_ER4K:  lim = tmo[CFG_SECTOR];
        OP_ER64K: lim = tmo[CFG_BLOCK];
        OP_CHIP:  lim = tmo[CFG_CHIP];
        default:  lim = tmo[CFG_PAGE];
      endcase
      if (elapsed >= {7'd0, lim}) done(OC_TIMEOUT);
      else status_read(K_POLL_CHECK);
    endfunction

    function void open_page();
      logic [12:0] room;
      room = 13'd256 - {5'd0, cur[7:0]};
      chunk = (rem < room) ? rem[8:0] : room[8:0];
      write_enable();
    endfunction

    function void address_done();
      case (op)
        OP_ID: begin
          rem = 13'd3; send(DUMMY); ph = P_READ_DATA;
        end
        OP_RESET, OP_WAKE: begin
          desel(); wait_ticks(TICKS_MS, K_DONE_OK);
        end
        OP_READ: begin
          if (rem == 0) begin
            desel(); done(OC_OK);
          end else begin
            send(DUMMY); ph = P_READ_DATA;
          end
        end
        OP_WRITE: begin
          put(ACT_NEED, 8'h00, 8'h00, OC_OK); ph = P_WR_NEED;
        end
        default: begin
          desel(); elapsed = '0; poll_busy();
        end
      endcase
    endfunction

    function void resume(phase_t k);
      case (k)
        K_STATUS_REPORT: begin
          put(ACT_HOST, 8'h00, stat, OC_OK); done(OC_OK);
        end
        K_WREN_RDSR: status_read(K_WREN_CHECK);
        K_WREN_CHECK: begin
          if (op == OP_WREN) begin
            put(ACT_HOST, 8'h00, stat, OC_OK);
            done(stat[1] ? OC_OK : OC_NOWEL);
          end else if (!stat[1]) begin
            done(OC_NOWEL);
          end else begin
            sel();
            case (op)
              OP_ER4K:  send(CMD_SE);
              OP_ER64K: send(CMD_BE);
              OP_CHIP:  send(CMD_CE);
              default:  send(CMD_PP);
            endcase
            step = (op == OP_CHIP) ? 3'd3 : 3'd0;
            ph = P_CMD_ADDR;
          end
        end
        K_POLL_CHECK: begin
          if (stat[0]) wait_ticks(TICKS_MS, K_POLL_NEXT);
          else if (op == OP_WRITE && rem != 0) open_page();
          else done(OC_OK);
        end
        K_POLL_NEXT: begin
          elapsed = elapsed + 27'd1; poll_busy();
        end
        K_PRE_SECOND: begin
          sel(); send(op == OP_ID ? CMD_WAKE : OPC_RESET_ENABLE); ph = P_PRE_CMD;
        end
        K_PRE_THIRD: begin
          sel(); send(op == OP_ID ? CMD_RDID : CMD_RST); step = 3'd3; ph = P_CMD_ADDR;
        end
        default: done(OC_OK);
      endcase
    endfunction

    function void start(in_item_t it);
      op = it.operation;
      case (op)
        OP_STATUS: status_read(K_STATUS_REPORT);
        OP_WREN:   write_enable();
        OP_ID, OP_RESET: begin
          desel(); wait_ticks(TICKS_PRE, K_PRE_SECOND);
        end
        OP_WAKE: begin
          sel(); send(CMD_WAKE); step = 3'd3; ph = P_CMD_ADDR;
        end
        OP_READ: begin
          if (it.length > 13'd4096) done(OC_BADARG);
          else begin
            cur = it.address; rem = it.length;
            sel(); send(OPC_READ_DATA); step = 3'd0; ph = P_CMD_ADDR;
          end
        end
        OP_ER4K, OP_ER64K: begin
          if ((op == OP_ER4K ? it.address[11:0] != 0 : it.address[15:0] != 0))
            done(OC_BADARG);
          else begin
            cur = it.address; write_enable();
          end
        end
        OP_CHIP: write_enable();
        OP_WRITE: begin
          if (it.length > 13'd4096) done(OC_BADARG);
          else begin
            cur = it.address; rem = it.length;
            if (it.length == 0) done(OC_OK);
            else open_page();
          end
        end
        default: done(OC_BADARG);
      endcase
    endfunction

    // Advance the predictor by one accepted input beat
    function void note_input(in_item_t it);
      burst.delete();
      case (it.req_type)
        REQ_START: if (ph == P_IDLE) start(it);
        REQ_TICK: if (ph == P_DELAY) begin
          if (dcnt > 0) dcnt--;
          if (dcnt == 0) resume(ret);
        end
        REQ_DATA: if (ph == P_WR_NEED) begin
          send(it.data_byte); ph = P_WR_SEND;
        end
        default: begin
          case (ph)
            P_RDSR_CMD: begin
              send(DUMMY); ph = P_RDSR_DATA;
            end
            P_RDSR_DATA: begin
              stat = it.data_byte; desel(); resume(ret);
            end
            P_WREN_CMD: begin
              desel(); wait_ticks(TICKS_WEL, K_WREN_RDSR);
            end
            P_PRE_CMD: begin
              desel(); wait_ticks(TICKS_PRE, K_PRE_THIRD);
            end
            P_CMD_ADDR: begin
              if (step < 3) begin
                send(8'(cur >> (16 - 8 * step))); step++;
              end else address_done();
            end
            P_READ_DATA: begin
              put(ACT_HOST, 8'h00, it.data_byte, OC_OK);
              if (rem > 0) rem--;
              if (rem != 0) send(DUMMY);
              else begin
                desel(); done(OC_OK);
              end
            end
            P_WR_SEND: begin
              if (chunk > 0) chunk--;
              if (rem > 0) rem--;
              cur = cur + 24'd1;
              if (chunk != 0) begin
                put(ACT_NEED, 8'h00, 8'h00, OC_OK); ph = P_WR_NEED;
              end else begin
                desel(); elapsed = '0; poll_busy();
              end
            end
            default: ;
          endcase
        end
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.action !== exp_r.action || got.spi_out_byte !== exp_r.spi_out_byte ||
          got.host_byte !== exp_r.host_byte || got.outcome !== exp_r.outcome ||
          got.last !== exp_r.last) begin
        $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  flash_scoreboard sb;
  int  in_beats;
  int  cfg_beats;
  int  quiet_cycles;
  int  sent_items;
  int  burst_left;
  bit  busy_ok;
  bit  hold_done;

  spi_nor_flash_command_sequencer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample handshakes, update the scoreboard, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
        in_beats++;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_timeout(cfg_index, cfg_data);
        cfg_beats++;
      end
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result stalls: ready at first, then one long hold-off, then random stalls with calm stretches
  initial begin
    int run;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (400) begin
      @(negedge clk);
      out_ready = 1'b1;
    end
    out_ready = 1'b0;
    repeat (HOLD_OFF) @(negedge clk);
    hold_done = 1'b1;
    forever begin
      run = $urandom_range(1, 40);
      if ($urandom_range(0, 2) == 0) begin
        repeat (run) begin
          out_ready = 1'b1;
          @(negedge clk);
        end
      end else begin
        repeat (run) begin
          out_ready = ($urandom_range(0, 2) != 0);
          @(negedge clk);
        end
      end
    end
  end

  // Build a start beat with biased sizes and alignment
  function automatic in_item_t rand_start();
    in_item_t it;
    int r;
    it.req_type  = REQ_START;
    it.address   = 24'($urandom());
    it.data_byte = 8'($urandom());
    it.length    = 13'($urandom_range(0, 12));
    r = $urandom_range(0, 19);
    it.operation = (r < 18) ? 4'(r % 10) : 4'($urandom_range(10, 15));
    case (it.operation)
      OP_ER4K:  if ($urandom_range(0, 4) != 0) it.address[11:0] = '0;
      OP_ER64K: if ($urandom_range(0, 4) != 0) it.address[15:0] = '0;
      OP_READ, OP_WRITE: begin
        if ($urandom_range(0, 1) == 1) it.address[7:0] = 8'($urandom_range(240, 255));
        r = $urandom_range(0, 39);
        if (r == 0) it.length = 13'($urandom_range(4097, 8191));
        else if (r == 1) it.length = 13'($urandom_range(256, 300));
      end
      default: ;
    endcase
    return it;
  endfunction

  // Answer what the block is waiting for, with random content
  function automatic in_item_t flash_answer();
    in_item_t it;
    it.req_type  = REQ_SPI;
    it.operation = 4'($urandom());
    it.address   = 24'($urandom());
    it.length    = 13'($urandom());
    it.data_byte = 8'($urandom());
    case (sb.ph)
      P_DELAY:   it.req_type = REQ_TICK;
      P_WR_NEED: it.req_type = REQ_DATA;
      P_RDSR_DATA: begin
        if (sb.ret == K_WREN_CHECK) it.data_byte[1] = ($urandom_range(0, 7) != 0);
        if (sb.ret == K_POLL_CHECK)
          it.data_byte[0] = busy_ok && ($urandom_range(0, 5) == 0);
      end
      default: ;
    endcase
    return it;
  endfunction

  // Offer one beat and wait for its acceptance; the sender idles in bursts
  task automatic send_beat(in_item_t it);
    int seen;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    seen = in_beats;
    in_valid = 1'b1;
    in_data  = it;
    do @(negedge clk); while (in_beats == seen);
    if (it.req_type != REQ_TICK) sent_items++;
  endtask

  // Run one operation to completion; noise beats mix in when asked
  task automatic run_op(in_item_t first, bit noisy);
    in_item_t it;
    send_beat(first);
    while (sb.ph != P_IDLE) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        it = flash_answer();
        it.req_type = 2'($urandom());
        if (it.req_type == REQ_START) it.operation = 4'($urandom());
      end else
        it = flash_answer();
      send_beat(it);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic load_timeout_reg(logic [1:0] idx, logic [19:0] val);
    int seen;
    seen = cfg_beats;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(negedge clk); while (cfg_beats == seen);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(int count, bit noisy);
    while (sent_items < count) run_op(rand_start(), noisy);
  endtask

  task automatic directed_op(logic [3:0] o, logic [23:0] a, logic [12:0] n);
    in_item_t it;
    it = '{req_type: REQ_START, operation: o, address: a, length: n, data_byte: 8'h00};
    run_op(it, 1'b0);
  endtask

  initial begin
    in_item_t stray;
    sb = new();
    in_beats = 0; cfg_beats = 0; quiet_cycles = 0; sent_items = 0; burst_left = 0;
    busy_ok = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Ignored beats while idle, then each operation and the edge cases
    stray = '{req_type: REQ_TICK, operation: 4'hF, address: 24'hFFFFFF,
              length: 13'h1FFF, data_byte: 8'hFF};
    send_beat(stray);
    stray.req_type = REQ_SPI;
    send_beat(stray);
    for (int o = 0; o < 10; o++) directed_op(4'(o), 24'h010000, 13'd3);
    directed_op(4'd15, 24'h0, 13'd0);
    directed_op(4'd10, 24'h0, 13'd0);
    directed_op(OP_READ, 24'hFFFFFF, 13'd0);
    directed_op(OP_READ, 24'h000000, 13'd4097);
    directed_op(OP_WRITE, 24'h000000, 13'd8191);
    directed_op(OP_WRITE, 24'h123456, 13'd0);
    directed_op(OP_ER4K, 24'h000800, 13'd0);
    directed_op(OP_ER64K, 24'h001000, 13'd0);
    directed_op(OP_WRITE, 24'hFFFFFE, 13'd4);
    directed_op(OP_READ, 24'h000000, 13'd4096);
    drain();

    // Short timeouts with busy polling
    load_timeout_reg(CFG_SECTOR, 20'd1);
    load_timeout_reg(CFG_BLOCK, 20'd2);
    load_timeout_reg(CFG_CHIP, 20'd3);
    load_timeout_reg(CFG_PAGE, 20'd2);
    busy_ok = 1'b1;
    run_random(sent_items + ITEMS / 2, 1'b1);
    drain();

    // Zero timeouts fail before the first poll
    for (int i = 0; i < 4; i++) load_timeout_reg(2'(i), 20'd0);
    run_random(sent_items + ITEMS / 4, 1'b1);
    drain();

    // Largest timeouts, flash never busy
    busy_ok = 1'b0;
    for (int i = 0; i < 4; i++) load_timeout_reg(2'(i), 20'hFFFFF);
    run_random(sent_items + ITEMS / 4, 1'b1);

    in_valid = 1'b0;
    while (sb.pending.size() != 0 || !hold_done) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/snfcs_pkg.sv
rtl/spi_nor_flash_command_sequencer.sv
test/spi_nor_flash_command_sequencer_tb.sv
